// ===== hw/rtl/gmp_pkg.sv =====
package gmp_pkg;

	localparam logic [1:0] CMD_INVAL = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READY = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	localparam logic [2:0] REG_FLAGS  = 3'd0;
	localparam logic [2:0] REG_THRESH = 3'd1;
	localparam logic [2:0] REG_RADIUS = 3'd2;
	localparam logic [2:0] REG_RES    = 3'd3;
	localparam logic [2:0] REG_ORG_X  = 3'd4;
	localparam logic [2:0] REG_ORG_Y  = 3'd5;
	localparam logic [2:0] REG_ROT    = 3'd6;
	localparam logic [2:0] REG_DIMS   = 3'd7;

	localparam logic [6:0]  THRESH_RST = 7'd50;
	localparam logic [23:0] RES_RST    = 24'd65536;
	localparam logic [31:0] ROT_RST    = 32'd16384;

	localparam logic [16:0] SQRT2_Q16  = 17'd92682;

	// divider dividend width, offset width, limit width
	localparam int DW = 36;
	localparam int OW = 44;
	localparam int LW = 26;

	typedef enum logic [1:0] {
		SEL_COL = 2'd0,
		SEL_ROW = 2'd1,
		SEL_RC  = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     ready_clr;
		logic     ready_set;
		logic     mem_we;
		logic     cap_point;
		logic     mul_en;
		logic     sum_en;
		logic     div_start;
		div_sel_t div_sel;
		logic     lat_col;
		logic     lat_row;
		logic     lat_rc;
		logic     win_en;
		logic     base_en;
		logic     off_en;
		logic     lim_en;
		logic     scan_en;
	} ctl_t;

	typedef struct packed {
		logic pre_ok;
		logic div_done;
		logic in_grid;
		logic scan_last;
		logic pipe_busy;
	} sts_t;

endpackage

// ===== hw/rtl/grid_map_proximity_check.sv =====
// channel        | ports                                         | transaction
// command in     | start, busy, cmd, cell_index, cell_value,     | start && !busy
//                | point_x, point_y, same_frame, point_finite    |
// result out     | done, near_occupied                           | done, one cycle
// configuration  | cfg_we, cfg_index, cfg_wdata                  | cfg_we
//
// invalidate, write cell and mark ready are handled in idle and keep busy low
// a query runs three divisions in turn on the shared 36-step divider, then scans
// the window, reading one cell per cycle from the cell store
// a rejected query answers in the cycle after it is taken
// reset clears map ready and loads register defaults; the cell store is not cleared
// done is high for one cycle and cannot be held off
module grid_map_proximity_check #(
	parameter int MAX_CELLS        = 65536,
	parameter int MAX_RADIUS_CELLS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [15:0]        cell_index,
	input  logic signed [7:0]  cell_value,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic               same_frame,
	input  logic               point_finite,
	output logic               done,
	output logic               near_occupied,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata
);

	gmp_pkg::ctl_t ctl;
	gmp_pkg::sts_t sts;
	logic          busy_w;

	gmp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !busy_w),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy_w),
		.done   (done)
	);

	gmp_dp #(
		.MAX_CELLS        (MAX_CELLS),
		.MAX_RADIUS_CELLS (MAX_RADIUS_CELLS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.cell_index    (cell_index),
		.cell_value    (cell_value),
		.point_x       (point_x),
		.point_y       (point_y),
		.same_frame    (same_frame),
		.point_finite  (point_finite),
		.near_occupied (near_occupied)
	);

	assign busy = busy_w;

endmodule

// ===== hw/rtl/gmp_ram.sv =====
module gmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/gmp_div.sv =====
module gmp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      neg,
	input  logic [gmp_pkg::DW-1:0]    dividend,
	input  logic [23:0]               divisor,
	output logic                      done,
	output logic signed [gmp_pkg::DW:0] quot
);

	localparam int CW = $clog2(gmp_pkg::DW);

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic [23:0]            d_q;
	logic [24:0]            rem_q;
	logic [gmp_pkg::DW-1:0] quo_q;
	logic [24:0]            rem_sh;
	logic                   take;
	logic [gmp_pkg::DW:0]   qext;

	assign rem_sh = {rem_q[23:0], quo_q[gmp_pkg::DW-1]};
	assign take   = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(gmp_pkg::DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= neg;
			d_q   <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {1'b0, d_q} : rem_sh;
			quo_q <= {quo_q[gmp_pkg::DW-2:0], take};
		end
	end

	// floor for negative dividends
	assign qext = {1'b0, quo_q};
	always_comb begin
		if (neg_q) begin
			quot = (rem_q != '0) ? $signed(~qext) : $signed(-qext);
		end else begin
			quot = $signed(qext);
		end
	end

	assign done = done_q;

endmodule

// ===== hw/rtl/gmp_dp.sv =====
module gmp_dp #(
	parameter int MAX_CELLS        = 65536,
	parameter int MAX_RADIUS_CELLS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gmp_pkg::ctl_t       ctl,
	output gmp_pkg::sts_t       sts,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic [15:0]         cell_index,
	input  logic signed [7:0]   cell_value,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic                same_frame,
	input  logic                point_finite,
	output logic                near_occupied
);

	localparam int AW = $clog2(MAX_CELLS);
	localparam int SW = $clog2(MAX_RADIUS_CELLS + 2);
	localparam int DW = gmp_pkg::DW;
	localparam int OW = gmp_pkg::OW;
	localparam int LW = gmp_pkg::LW;

	logic [1:0]  flags_q;
	logic [6:0]  thr_q;
	logic [23:0] radius_q;
	logic [23:0] res_q;
	logic [31:0] org_x_q;
	logic [31:0] org_y_q;
	logic [31:0] rot_q;
	logic [31:0] dims_q;
	logic        ready_q;

	logic [15:0] map_w;
	logic [15:0] map_h;
	logic        dims_ok;

	assign map_w   = dims_q[15:0];
	assign map_h   = dims_q[31:16];
	assign dims_ok = (map_w != '0) && (map_h != '0) && (res_q != '0) &&
	                 ((32'(map_w) * 32'(map_h)) <= 32'(MAX_CELLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			thr_q    <= gmp_pkg::THRESH_RST;
			radius_q <= '0;
			res_q    <= gmp_pkg::RES_RST;
			org_x_q  <= '0;
			org_y_q  <= '0;
			rot_q    <= gmp_pkg::ROT_RST;
			dims_q   <= '0;
			ready_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gmp_pkg::REG_FLAGS:  flags_q  <= cfg_wdata[1:0];
					gmp_pkg::REG_THRESH: thr_q    <= cfg_wdata[6:0];
					gmp_pkg::REG_RADIUS: radius_q <= cfg_wdata[23:0];
					gmp_pkg::REG_RES:    res_q    <= cfg_wdata[23:0];
					gmp_pkg::REG_ORG_X:  org_x_q  <= cfg_wdata;
					gmp_pkg::REG_ORG_Y:  org_y_q  <= cfg_wdata;
					gmp_pkg::REG_ROT:    rot_q    <= cfg_wdata;
					gmp_pkg::REG_DIMS:   dims_q   <= cfg_wdata;
					default: ;
				endcase
			end
			if (ctl.ready_clr) begin
				ready_q <= 1'b0;
			end else if (ctl.ready_set) begin
				ready_q <= dims_ok;
			end
		end
	end

	// cell store
	logic          ram_we;
	logic [AW-1:0] addr_q;
	logic [7:0]    rd_data;

	assign ram_we = ctl.mem_we && (32'(cell_index) < 32'(MAX_CELLS));

	gmp_ram #(
		.WIDTH (8),
		.DEPTH (MAX_CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cell_index)),
		.wdata (cell_value),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// point into map frame
	logic signed [32:0] dx_q, dy_q;
	logic signed [48:0] p_cdx_q, p_sdy_q, p_cdy_q, p_sdx_q;
	logic signed [49:0] sum_x, sum_y;
	logic signed [35:0] mx_q, my_q;
	logic signed [15:0] cos_v, sin_v;

	assign cos_v = $signed(rot_q[15:0]);
	assign sin_v = $signed(rot_q[31:16]);
	assign sum_x = {p_cdx_q[48], p_cdx_q} + {p_sdy_q[48], p_sdy_q};
	assign sum_y = {p_cdy_q[48], p_cdy_q} - {p_sdx_q[48], p_sdx_q};

	always_ff @(posedge clk) begin
		if (ctl.cap_point) begin
			dx_q <= $signed({point_x[31], point_x}) - $signed({org_x_q[31], org_x_q});
			dy_q <= $signed({point_y[31], point_y}) - $signed({org_y_q[31], org_y_q});
		end
		if (ctl.mul_en) begin
			p_cdx_q <= 49'(cos_v) * 49'(dx_q);
			p_sdy_q <= 49'(sin_v) * 49'(dy_q);
			p_cdy_q <= 49'(cos_v) * 49'(dy_q);
			p_sdx_q <= 49'(sin_v) * 49'(dx_q);
		end
		if (ctl.sum_en) begin
			mx_q <= sum_x[49:14];
			my_q <= sum_y[49:14];
		end
	end

	// shared divider
	logic                 div_neg;
	logic [DW-1:0]        div_num;
	logic                 div_done;
	logic signed [DW:0]   div_quot;

	always_comb begin
		case (ctl.div_sel)
			gmp_pkg::SEL_COL: begin
				div_neg = mx_q[35];
				div_num = mx_q[35] ? DW'(-mx_q) : DW'(mx_q);
			end
			gmp_pkg::SEL_ROW: begin
				div_neg = my_q[35];
				div_num = my_q[35] ? DW'(-my_q) : DW'(my_q);
			end
			default: begin
				div_neg = 1'b0;
				div_num = DW'(radius_q) + DW'(res_q) - DW'(1);
			end
		endcase
	end

	gmp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.neg      (div_neg),
		.dividend (div_num),
		.divisor  (res_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	logic signed [DW:0] col_q, row_q;
	logic [SW-1:0]      span_q;

	always_ff @(posedge clk) begin
		if (ctl.lat_col) begin
			col_q <= div_quot;
		end
		if (ctl.lat_row) begin
			row_q <= div_quot;
		end
		if (ctl.lat_rc) begin
			span_q <= (div_quot[DW-1:0] > DW'(MAX_RADIUS_CELLS)) ?
			          SW'(MAX_RADIUS_CELLS + 1) : SW'(div_quot[SW-1:0]) + SW'(1);
		end
	end

	// window bounds
	logic [16:0] colx, rowx, spanx, col_hi, row_hi;
	logic [15:0] c0_q, c1_q, r0_q, r1_q;

	assign colx   = {1'b0, col_q[15:0]};
	assign rowx   = {1'b0, row_q[15:0]};
	assign spanx  = 17'(span_q);
	assign col_hi = colx + spanx;
	assign row_hi = rowx + spanx;

	always_ff @(posedge clk) begin
		if (ctl.win_en) begin
			c0_q <= (colx >= spanx) ? 16'(colx - spanx) : '0;
			r0_q <= (rowx >= spanx) ? 16'(rowx - spanx) : '0;
			c1_q <= (col_hi >= {1'b0, map_w}) ? map_w - 16'd1 : col_hi[15:0];
			r1_q <= (row_hi >= {1'b0, map_h}) ? map_h - 16'd1 : row_hi[15:0];
		end
	end

	// scan setup
	logic [39:0]   c0r_q, r0r_q;
	logic [31:0]   r0w_q;
	logic [40:0]   resq_q;
	logic [40:0]   resq_rnd;
	logic [OW-1:0] ox_start_q, ox_q, oy_q, step2;
	logic [LW-1:0] limit_q;
	logic [2*LW-1:0] lim2_q;
	logic [AW-1:0] addr_row_q;
	logic [15:0]   k_q, r_q;

	assign resq_rnd = resq_q + 41'd32768;
	assign step2    = {{(OW-25){1'b0}}, res_q, 1'b0};

	always_ff @(posedge clk) begin
		if (ctl.base_en) begin
			c0r_q  <= 40'(c0_q) * 40'(res_q);
			r0r_q  <= 40'(r0_q) * 40'(res_q);
			r0w_q  <= 32'(r0_q) * 32'(map_w);
			resq_q <= 41'(res_q) * 41'(gmp_pkg::SQRT2_Q16);
		end
		if (ctl.off_en) begin
			ox_start_q <= {3'b0, c0r_q, 1'b0} + OW'(res_q) -
			              {{(OW-37){mx_q[35]}}, mx_q, 1'b0};
			oy_q       <= {3'b0, r0r_q, 1'b0} + OW'(res_q) -
			              {{(OW-37){my_q[35]}}, my_q, 1'b0};
			limit_q    <= {1'b0, radius_q, 1'b0} + LW'(resq_rnd[40:16]);
			addr_row_q <= AW'(r0w_q + 32'(c0_q));
		end
		if (ctl.lim_en) begin
			lim2_q <= (2*LW)'(limit_q) * (2*LW)'(limit_q);
			k_q    <= c0_q;
			r_q    <= r0_q;
			addr_q <= addr_row_q;
			ox_q   <= ox_start_q;
		end else if (ctl.scan_en) begin
			if (k_q == c1_q) begin
				k_q        <= c0_q;
				r_q        <= r_q + 16'd1;
				addr_row_q <= addr_row_q + AW'(map_w);
				addr_q     <= addr_row_q + AW'(map_w);
				ox_q       <= ox_start_q;
				oy_q       <= oy_q + step2;
			end else begin
				k_q    <= k_q + 16'd1;
				addr_q <= addr_q + AW'(1);
				ox_q   <= ox_q + step2;
			end
		end
	end

	// evaluation pipeline
	logic            v_s1, v_s2, v_s3;
	logic [OW-1:0]   ox_s1, oy_s1;
	logic [OW-1:0]   abs_x, abs_y;
	logic            occ;
	logic            occ_s2, occ_s3;
	logic [LW-1:0]   ax_s2, ay_s2;
	logic [2*LW-1:0] sqx_s3, sqy_s3;
	logic            hit_q;

	assign abs_x = ox_s1[OW-1] ? -ox_s1 : ox_s1;
	assign abs_y = oy_s1[OW-1] ? -oy_s1 : oy_s1;

	always_comb begin
		if (rd_data[7]) begin
			occ = flags_q[1];
		end else begin
			occ = rd_data[6:0] >= thr_q;
		end
		occ = occ && v_s1 && (abs_x <= OW'(limit_q)) && (abs_y <= OW'(limit_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			v_s1 <= ctl.scan_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (ctl.cap_point) begin
				hit_q <= 1'b0;
			end else if (v_s3 && occ_s3 &&
			             ({1'b0, sqx_s3} + {1'b0, sqy_s3} <= {1'b0, lim2_q})) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ox_s1  <= ox_q;
		oy_s1  <= oy_q;
		occ_s2 <= occ;
		ax_s2  <= abs_x[LW-1:0];
		ay_s2  <= abs_y[LW-1:0];
		occ_s3 <= occ_s2;
		sqx_s3 <= (2*LW)'(ax_s2) * (2*LW)'(ax_s2);
		sqy_s3 <= (2*LW)'(ay_s2) * (2*LW)'(ay_s2);
	end

	assign near_occupied = hit_q;

	always_comb begin
		sts.pre_ok    = flags_q[0] && ready_q && dims_ok && same_frame && point_finite;
		sts.div_done  = div_done;
		sts.in_grid   = !col_q[DW] && (col_q[DW-1:0] < DW'(map_w)) &&
		                !row_q[DW] && (row_q[DW-1:0] < DW'(map_h));
		sts.scan_last = (k_q == c1_q) && (r_q == r1_q);
		sts.pipe_busy = v_s1 || v_s2 || v_s3;
	end

endmodule

// ===== hw/rtl/gmp_ctrl.sv =====
module gmp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     cmd,
	input  gmp_pkg::sts_t  sts,
	output gmp_pkg::ctl_t  ctl,
	output logic           busy,
	output logic           done
);

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_MUL    = 14'b00000000000010,
		ST_SUM    = 14'b00000000000100,
		ST_DSTART = 14'b00000000001000,
		ST_DCOL   = 14'b00000000010000,
		ST_DROW   = 14'b00000000100000,
		ST_DRC    = 14'b00000001000000,
		ST_WIN    = 14'b00000010000000,
		ST_BASE   = 14'b00000100000000,
		ST_OFF    = 14'b00001000000000,
		ST_LIM    = 14'b00010000000000,
		ST_SCAN   = 14'b00100000000000,
		ST_DRAIN  = 14'b01000000000000,
		ST_DONE   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd)
						gmp_pkg::CMD_INVAL: ctl.ready_clr = 1'b1;
						gmp_pkg::CMD_WRITE: ctl.mem_we    = 1'b1;
						gmp_pkg::CMD_READY: ctl.ready_set = 1'b1;
						gmp_pkg::CMD_QUERY: begin
							ctl.cap_point = 1'b1;
							state_d = sts.pre_ok ? ST_MUL : ST_DONE;
						end
						default: ;
					endcase
				end
			end
			ST_MUL: begin
				ctl.mul_en = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				ctl.sum_en = 1'b1;
				state_d = ST_DSTART;
			end
			ST_DSTART: begin
				ctl.div_start = 1'b1;
				ctl.div_sel   = gmp_pkg::SEL_COL;
				state_d = ST_DCOL;
			end
			ST_DCOL: begin
				if (sts.div_done) begin
					ctl.lat_col   = 1'b1;
					ctl.div_start = 1'b1;
					ctl.div_sel   = gmp_pkg::SEL_ROW;
					state_d = ST_DROW;
				end
			end
			ST_DROW: begin
				if (sts.div_done) begin
					ctl.lat_row   = 1'b1;
					ctl.div_start = 1'b1;
					ctl.div_sel   = gmp_pkg::SEL_RC;
					state_d = ST_DRC;
				end
			end
			ST_DRC: begin
				if (sts.div_done) begin
					ctl.lat_rc = 1'b1;
					state_d = ST_WIN;
				end
			end
			ST_WIN: begin
				ctl.win_en = 1'b1;
				state_d = sts.in_grid ? ST_BASE : ST_DONE;
			end
			ST_BASE: begin
				ctl.base_en = 1'b1;
				state_d = ST_OFF;
			end
			ST_OFF: begin
				ctl.off_en = 1'b1;
				state_d = ST_LIM;
			end
			ST_LIM: begin
				ctl.lim_en = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				ctl.scan_en = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule
